// ===== design/alddm_pkg.sv =====
// Shared types, constants and helper functions of the ambient light display dimmer.
package alddm_pkg;

	// Field and state widths.
	localparam int WIN_W      = 12;
	localparam int RAMP_W     = 8;
	localparam int SUM_W      = 29;
	localparam int CNT_W      = 13;
	localparam int LIGHT_W    = 16;
	localparam int PERIOD_W   = 7;
	localparam int DIGIT_W    = 4;
	localparam int DIVIDEND_W = SUM_W + 1;
	localparam int SAMPLE_W   = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = WIN_W;

	// Default sample resolution of the converter.
	localparam int SAMPLE_BITS_DEF = 16;

	// Reset values and dimming constants.
	localparam logic [WIN_W-1:0]    WINDOW_RESET = WIN_W'(2000);
	localparam logic [RAMP_W-1:0]   RAMP_RESET   = RAMP_W'(30);
	localparam logic [LIGHT_W-1:0]  LIGHT_CLAMP  = LIGHT_W'(241);
	localparam logic [PERIOD_W-1:0] PERIOD_TOP   = PERIOD_W'(72);
	localparam logic [PERIOD_W-1:0] PERIOD_STEP  = PERIOD_W'(8);
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(8);
	localparam int                  LEVEL_DIV    = 30;
	localparam int                  LEVEL_COUNT  = 8;

	// Request codes.
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_LEN    = 1'b0,
		REG_RAMP_INTERVAL = 1'b1
	} cfg_reg_t;

	// Request to the shared divide and digit unit.
	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [CNT_W-1:0]      divisor;
	} calc_req_t;

	// Status and results of the shared divide and digit unit.
	typedef struct packed {
		logic               busy;
		logic               done;
		logic [LIGHT_W-1:0] quotient;
		logic [DIGIT_W-1:0] hundreds;
		logic [DIGIT_W-1:0] tens;
		logic [DIGIT_W-1:0] ones;
	} calc_rsp_t;

	// Limit the light value to the clamp level.
	function automatic logic [LIGHT_W-1:0] clamp_light(input logic [LIGHT_W-1:0] light);
		return (light > LIGHT_CLAMP) ? LIGHT_CLAMP : light;
	endfunction

	// Scan period target: top value less one step per level of thirty.
	function automatic logic [PERIOD_W-1:0] period_target(input logic [LIGHT_W-1:0] light);
		logic [DIGIT_W-1:0] level;
		level = '0;
		for (int k = 1; k <= LEVEL_COUNT; k++) begin
			if (light >= LIGHT_W'(k * LEVEL_DIV)) begin
				level = level + DIGIT_W'(1);
			end
		end
		return PERIOD_TOP - PERIOD_W'({level, 3'b000});
	endfunction

endpackage

// ===== design/alddm_item_if.sv =====
// Request channel of the dimmer: a sensor sample or a timer tick.
interface alddm_item_if;
	logic                          valid;
	logic                          ready;
	logic                          command;
	logic [alddm_pkg::SAMPLE_W-1:0] sample;

	modport source (output valid, command, sample, input ready);
	modport sink (input valid, command, sample, output ready);
endinterface

// ===== design/alddm_result_if.sv =====
// Result channel of the dimmer: light value, digits and scan period.
interface alddm_result_if;
	logic                           valid;
	logic                           ready;
	logic [alddm_pkg::LIGHT_W-1:0]  avg_light;
	logic                           new_average;
	logic [alddm_pkg::DIGIT_W-1:0]  digit_hundreds;
	logic [alddm_pkg::DIGIT_W-1:0]  digit_tens;
	logic [alddm_pkg::DIGIT_W-1:0]  digit_ones;
	logic [alddm_pkg::PERIOD_W-1:0] scan_period;

	modport source (output valid, avg_light, new_average, digit_hundreds, digit_tens,
		digit_ones, scan_period, input ready);
	modport sink (input valid, avg_light, new_average, digit_hundreds, digit_tens,
		digit_ones, scan_period, output ready);
endinterface

// ===== design/alddm_calc.sv =====
// Shared iterative unit: restoring divider followed by a binary to decimal conversion.
module alddm_calc (
	input  logic                 clk,
	input  logic                 arst_n,
	input  alddm_pkg::calc_req_t req,
	output alddm_pkg::calc_rsp_t rsp
);

	localparam int DIV_W  = alddm_pkg::DIVIDEND_W;
	localparam int DEN_W  = alddm_pkg::CNT_W;
	localparam int BIN_W  = alddm_pkg::LIGHT_W;
	localparam int DIG_W  = alddm_pkg::DIGIT_W;
	localparam int BCD_W  = 3 * DIG_W;
	localparam int STEP_W = $clog2(DIV_W);

	typedef enum logic [1:0] {
		CALC_IDLE,
		CALC_DIV,
		CALC_BCD
	} calc_state_t;

	calc_state_t        state_q;
	logic [STEP_W-1:0]  step_q;
	logic [DEN_W-1:0]   rem_q;
	logic [DEN_W-1:0]   divisor_q;
	logic [DIV_W-1:0]   work_q;
	logic [BIN_W-1:0]   quotient_q;
	logic [BCD_W-1:0]   bcd_q;
	logic               done_q;

	logic [DEN_W:0]     shifted;
	logic [DEN_W+1:0]   diff;
	logic               fits;
	logic [DEN_W-1:0]   rem_next;
	logic [DIV_W-1:0]   work_next;
	logic [BCD_W-1:0]   bcd_adj;

	// One restoring division step: trial subtraction of the divisor.
	always_comb begin
		shifted   = {rem_q, work_q[DIV_W-1]};
		diff      = {1'b0, shifted} - {2'b00, divisor_q};
		fits      = !diff[DEN_W+1];
		rem_next  = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
		work_next = {work_q[DIV_W-2:0], fits};
	end

	// One double-dabble step: digits of five or more are raised by three before the shift.
	// Only three digits are kept, so the result is the value modulo one thousand.
	always_comb begin
		for (int d = 0; d < 3; d++) begin
			bcd_adj[d*DIG_W +: DIG_W] = (bcd_q[d*DIG_W +: DIG_W] >= DIG_W'(5)) ?
				bcd_q[d*DIG_W +: DIG_W] + DIG_W'(3) : bcd_q[d*DIG_W +: DIG_W];
		end
	end

	// Sequencer and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= CALC_IDLE;
			step_q     <= '0;
			rem_q      <= '0;
			divisor_q  <= '0;
			work_q     <= '0;
			quotient_q <= '0;
			bcd_q      <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				CALC_IDLE: begin
					if (req.start) begin
						step_q    <= '0;
						rem_q     <= '0;
						bcd_q     <= '0;
						divisor_q <= req.divisor;
						if (req.divisor == '0) begin
							// An empty window averages to zero.
							work_q     <= '0;
							quotient_q <= '0;
							state_q    <= CALC_BCD;
						end else begin
							work_q  <= req.dividend;
							state_q <= CALC_DIV;
						end
					end
				end
				CALC_DIV: begin
					rem_q  <= rem_next;
					work_q <= work_next;
					if (step_q == STEP_W'(DIV_W - 1)) begin
						step_q     <= '0;
						quotient_q <= work_next[BIN_W-1:0];
						state_q    <= CALC_BCD;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				CALC_BCD: begin
					bcd_q  <= {bcd_adj[BCD_W-2:0], work_q[BIN_W-1]};
					work_q <= {work_q[DIV_W-2:0], 1'b0};
					if (step_q == STEP_W'(BIN_W - 1)) begin
						step_q  <= '0;
						done_q  <= 1'b1;
						state_q <= CALC_IDLE;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				default: begin
					state_q <= CALC_IDLE;
				end
			endcase
		end
	end

	assign rsp.busy     = (state_q != CALC_IDLE);
	assign rsp.done     = done_q;
	assign rsp.quotient = quotient_q;
	assign rsp.hundreds = bcd_q[2*DIG_W +: DIG_W];
	assign rsp.tens     = bcd_q[DIG_W +: DIG_W];
	assign rsp.ones     = bcd_q[0 +: DIG_W];

endmodule

// ===== design/ambient_light_display_dimmer.sv =====
// Top level of the ambient light display dimmer: request handling, state and result register.
//
// Requests arrive on the item channel: command 0 carries a light sample, command 1 a timer
// tick. Each request yields exactly one result on the result channel, in order. Samples are
// summed; once the event count passes window_len a rounded average is formed and its decimal
// digits are taken. After every ramp_interval+1 ticks the light value is clamped to 241 and
// the scan period moves one step of eight toward its target.
// A tick or a sample that forms no average is taken in ST_IDLE, and ST_FINISH then loads
// the result register. A sample that closes a window runs through the shared
// divide and digit unit: ST_IDLE takes the request and loads the unit, 30 division steps
// and 16 conversion steps follow, then ST_CALC takes the unit's result and ST_FINISH loads
// the result register. The block takes one request at a time and is not
// ready while the unit runs.
// The result register holds a finished result while the receiver stalls; the next request
// is still taken and its result waits until the register is free.
// Configuration writes (window_len at index 0, ramp_interval at index 1) take effect at once;
// the user must make them while the block is idle, which the block itself does not enforce.
// Reset sets window_len to 2000, ramp_interval to 30, the scan period to 8 and clears all counters, sums and digits.
module ambient_light_display_dimmer #(
	parameter int SAMPLE_BITS = alddm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	alddm_item_if.sink                       item,
	alddm_result_if.source                   result,
	input  logic                             cfg_we,
	input  logic [alddm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [alddm_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int WIN_W    = alddm_pkg::WIN_W;
	localparam int RAMP_W   = alddm_pkg::RAMP_W;
	localparam int SUM_W    = alddm_pkg::SUM_W;
	localparam int CNT_W    = alddm_pkg::CNT_W;
	localparam int LIGHT_W  = alddm_pkg::LIGHT_W;
	localparam int PERIOD_W = alddm_pkg::PERIOD_W;
	localparam int DIGIT_W  = alddm_pkg::DIGIT_W;
	localparam int DIV_W    = alddm_pkg::DIVIDEND_W;
	localparam int SMP_W    = alddm_pkg::SAMPLE_W;
	localparam logic [SMP_W-1:0] SAMPLE_MASK = SMP_W'((64'd1 << SAMPLE_BITS) - 64'd1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_FINISH
	} top_state_t;

	top_state_t           state_q;
	logic [WIN_W-1:0]     window_q;
	logic [RAMP_W-1:0]    ramp_q;
	logic [WIN_W-1:0]     event_q;
	logic [CNT_W-1:0]     scount_q;
	logic [SUM_W-1:0]     sum_q;
	logic [LIGHT_W-1:0]   light_q;
	logic [DIGIT_W-1:0]   hund_q;
	logic [DIGIT_W-1:0]   tens_q;
	logic [DIGIT_W-1:0]   ones_q;
	logic [PERIOD_W-1:0]  period_q;
	logic [RAMP_W-1:0]    tick_q;
	logic                 started_q;
	logic                 fresh_q;

	logic                 out_valid_q;
	logic [LIGHT_W-1:0]   out_light_q;
	logic                 out_fresh_q;
	logic [DIGIT_W-1:0]   out_hund_q;
	logic [DIGIT_W-1:0]   out_tens_q;
	logic [DIGIT_W-1:0]   out_ones_q;
	logic [PERIOD_W-1:0]  out_period_q;

	alddm_pkg::calc_req_t calc_req;
	alddm_pkg::calc_rsp_t calc_rsp;

	logic                 accept;
	logic [SMP_W-1:0]     smp;
	logic [WIN_W:0]       event_next;
	logic                 window_done;
	logic [RAMP_W:0]      tick_next;
	logic                 ramp_fire;
	logic [LIGHT_W-1:0]   light_clamped;
	logic [PERIOD_W-1:0]  ramp_target;
	logic [PERIOD_W-1:0]  period_ramped;
	logic [LIGHT_W-1:0]   avg_clamped;
	logic                 out_free;

	// Request decode and counter comparisons.
	always_comb begin
		accept        = item.valid && item.ready;
		smp           = item.sample & SAMPLE_MASK;
		event_next    = {1'b0, event_q} + (WIN_W+1)'(1);
		window_done   = (event_next > {1'b0, window_q});
		tick_next     = {1'b0, tick_q} + (RAMP_W+1)'(1);
		ramp_fire     = (tick_next > {1'b0, ramp_q});
		light_clamped = alddm_pkg::clamp_light(light_q);
		ramp_target   = alddm_pkg::period_target(light_clamped);
		avg_clamped   = alddm_pkg::clamp_light(calc_rsp.quotient);
		out_free      = !out_valid_q || result.ready;
	end

	// Ramp step: move the period one step toward the target.
	always_comb begin
		if (period_q > ramp_target) begin
			period_ramped = period_q - alddm_pkg::PERIOD_STEP;
		end else if (period_q < ramp_target) begin
			period_ramped = period_q + alddm_pkg::PERIOD_STEP;
		end else begin
			period_ramped = period_q;
		end
	end

	// Average request to the shared unit: rounded by half the count.
	always_comb begin
		calc_req.start    = accept && (item.command == alddm_pkg::CMD_SAMPLE) && window_done;
		calc_req.dividend = DIV_W'(sum_q) + DIV_W'(scount_q >> 1);
		calc_req.divisor  = scount_q;
	end

	alddm_calc u_calc (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (calc_req),
		.rsp    (calc_rsp)
	);

	// Sequencer, dimmer state, configuration and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			window_q     <= alddm_pkg::WINDOW_RESET;
			ramp_q       <= alddm_pkg::RAMP_RESET;
			event_q      <= '0;
			scount_q     <= '0;
			sum_q        <= '0;
			light_q      <= '0;
			hund_q       <= '0;
			tens_q       <= '0;
			ones_q       <= '0;
			period_q     <= alddm_pkg::PERIOD_RESET;
			tick_q       <= '0;
			started_q    <= 1'b0;
			fresh_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			out_light_q  <= '0;
			out_fresh_q  <= 1'b0;
			out_hund_q   <= '0;
			out_tens_q   <= '0;
			out_ones_q   <= '0;
			out_period_q <= '0;
		end else begin
			// Configuration writes.
			if (cfg_we) begin
				case (alddm_pkg::cfg_reg_t'(cfg_index))
					alddm_pkg::REG_WINDOW_LEN:    window_q <= cfg_data;
					alddm_pkg::REG_RAMP_INTERVAL: ramp_q   <= cfg_data[RAMP_W-1:0];
					default: ;
				endcase
			end

			// The receiver has taken the held result and no new one replaces it.
			if (out_valid_q && result.ready && (state_q != ST_FINISH)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						fresh_q <= 1'b0;
						case (item.command)
							alddm_pkg::CMD_SAMPLE: begin
								if (window_done) begin
									// The closing sample opens the next window.
									event_q  <= '0;
									scount_q <= CNT_W'(1);
									sum_q    <= SUM_W'(smp);
									state_q  <= ST_CALC;
								end else begin
									event_q  <= event_next[WIN_W-1:0];
									scount_q <= scount_q + CNT_W'(1);
									sum_q    <= sum_q + SUM_W'(smp);
									state_q  <= ST_FINISH;
								end
							end
							alddm_pkg::CMD_TICK: begin
								if (ramp_fire) begin
									tick_q   <= '0;
									light_q  <= light_clamped;
									period_q <= period_ramped;
								end else begin
									tick_q <= tick_next[RAMP_W-1:0];
								end
								state_q <= ST_FINISH;
							end
							default: begin
								state_q <= ST_FINISH;
							end
						endcase
					end
				end
				ST_CALC: begin
					if (calc_rsp.done) begin
						fresh_q <= 1'b1;
						hund_q  <= calc_rsp.hundreds;
						tens_q  <= calc_rsp.tens;
						ones_q  <= calc_rsp.ones;
						// The first nonzero average sets the period directly.
						if (!started_q && (calc_rsp.quotient != '0)) begin
							started_q <= 1'b1;
							light_q   <= avg_clamped;
							period_q  <= alddm_pkg::period_target(avg_clamped);
						end else begin
							light_q <= calc_rsp.quotient;
						end
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_light_q  <= light_q;
						out_fresh_q  <= fresh_q;
						out_hund_q   <= hund_q;
						out_tens_q   <= tens_q;
						out_ones_q   <= ones_q;
						out_period_q <= period_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign item.ready            = (state_q == ST_IDLE);
	assign result.valid          = out_valid_q;
	assign result.avg_light      = out_light_q;
	assign result.new_average    = out_fresh_q;
	assign result.digit_hundreds = out_hund_q;
	assign result.digit_tens     = out_tens_q;
	assign result.digit_ones     = out_ones_q;
	assign result.scan_period    = out_period_q;

	// The scan period stays a multiple of eight between its limits.
	a_period_range: assert property (@(posedge clk) disable iff (!arst_n)
		(period_q[2:0] == 3'b000) && (period_q >= alddm_pkg::PERIOD_RESET) &&
		(period_q <= alddm_pkg::PERIOD_TOP))
		else $error("scan period out of range");

	// Once the first nonzero average has been seen, it stays seen.
	a_started_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |=> started_q)
		else $error("started flag dropped");

	// A request is never taken while the shared unit is still working.
	a_ready_unit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item.ready |-> !calc_rsp.busy)
		else $error("ready while divide unit busy");

	// Every digit held in the result register is a decimal digit.
	a_digits_decimal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_hund_q <= DIGIT_W'(9)) && (out_tens_q <= DIGIT_W'(9)) &&
		(out_ones_q <= DIGIT_W'(9)))
		else $error("digit out of decimal range");

	// The unit reports completion only while the sequencer waits for it.
	a_done_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		calc_rsp.done |-> (state_q == ST_CALC))
		else $error("divide unit finished outside the average step");

endmodule

// ===== tb/ambient_light_display_dimmer_test.sv =====
// Self-checking testbench of the ambient light display dimmer: predictor, scoreboard and drivers.
module ambient_light_display_dimmer_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SAMPLE_BITS = alddm_pkg::SAMPLE_BITS_DEF;
	localparam int SAMPLE_W    = alddm_pkg::SAMPLE_W;
	localparam int LIGHT_W     = alddm_pkg::LIGHT_W;
	localparam int DIGIT_W     = alddm_pkg::DIGIT_W;
	localparam int PERIOD_W    = alddm_pkg::PERIOD_W;
	localparam int WIN_W       = alddm_pkg::WIN_W;
	localparam int RAMP_W      = alddm_pkg::RAMP_W;
	localparam int CNT_W       = alddm_pkg::CNT_W;
	localparam int SUM_W       = alddm_pkg::SUM_W;
	localparam int CFG_IDX_W   = alddm_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W  = alddm_pkg::CFG_DATA_W;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 40;
	localparam int WIDE_TICKS = 260;

	// One result of the dimmer, as seen on the result channel.
	typedef struct packed {
		logic [LIGHT_W-1:0]  avg_light;
		logic                new_average;
		logic [DIGIT_W-1:0]  hundreds;
		logic [DIGIT_W-1:0]  tens;
		logic [DIGIT_W-1:0]  ones;
		logic [PERIOD_W-1:0] scan_period;
	} dimmer_result_t;

	// Tracks the dimmer's state, works out each request's result and checks what comes out.
	class dimmer_tracker;
		logic [WIN_W-1:0]    window_len;
		logic [RAMP_W-1:0]   ramp_interval;
		logic [WIN_W-1:0]    event_count;
		logic [CNT_W-1:0]    sample_count;
		logic [SUM_W-1:0]    sample_sum;
		logic [LIGHT_W-1:0]  light;
		logic [DIGIT_W-1:0]  hundreds;
		logic [DIGIT_W-1:0]  tens;
		logic [DIGIT_W-1:0]  ones;
		logic [PERIOD_W-1:0] period;
		logic [RAMP_W-1:0]   tick_count;
		bit                  started;
		dimmer_result_t      pending_results[$];
		int                  mismatch_count;

		function new();
			window_len = alddm_pkg::WINDOW_RESET;
			ramp_interval = alddm_pkg::RAMP_RESET;
			event_count = '0;
			sample_count = '0;
			sample_sum = '0;
			light = '0;
			hundreds = '0;
			tens = '0;
			ones = '0;
			period = alddm_pkg::PERIOD_RESET;
			tick_count = '0;
			started = 1'b0;
			mismatch_count = 0;
		endfunction

		function void write_register(alddm_pkg::cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				alddm_pkg::REG_WINDOW_LEN: begin
					window_len = value[WIN_W-1:0];
				end
				alddm_pkg::REG_RAMP_INTERVAL: begin
					ramp_interval = value[RAMP_W-1:0];
				end
				default: ;
			endcase
		endfunction

		// Clamp the light value and return the scan period that the clamped level calls for.
		function logic [PERIOD_W-1:0] clamped_target();
			if (light > alddm_pkg::LIGHT_CLAMP) begin
				light = alddm_pkg::LIGHT_CLAMP;
			end
			return alddm_pkg::PERIOD_TOP -
				PERIOD_W'(int'(light) / alddm_pkg::LEVEL_DIV) * alddm_pkg::PERIOD_STEP;
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction

		// Advance the state by one accepted request and queue the result that it should give.
		function void note_request(logic cmd, logic [SAMPLE_W-1:0] raw);
			logic [SAMPLE_W-1:0] value;
			logic [WIN_W:0]      next_event;
			logic [RAMP_W:0]     next_tick;
			logic [31:0]         average;
			logic [PERIOD_W-1:0] target;
			logic                fresh;
			dimmer_result_t      expected;
			fresh = 1'b0;
			if (cmd == alddm_pkg::CMD_SAMPLE) begin
				value = raw & SAMPLE_W'((32'd1 << SAMPLE_BITS) - 1);
				next_event = {1'b0, event_count} + (WIN_W+1)'(1);
				// The window closes on the incremented count, one bit wider than the counter.
				if (next_event > {1'b0, window_len}) begin
					average = '0;
					if (sample_count != '0) begin
						average = (32'(sample_sum) + 32'(sample_count >> 1)) / 32'(sample_count);
					end
					light = average[LIGHT_W-1:0];
					sample_sum = '0;
					sample_count = '0;
					event_count = '0;
					hundreds = DIGIT_W'((int'(light) % 1000) / 100);
					tens = DIGIT_W'((int'(light) % 100) / 10);
					ones = DIGIT_W'(int'(light) % 10);
					fresh = 1'b1;
					// The first nonzero average sets the period straight to its target.
					if (!started && light != '0) begin
						started = 1'b1;
						period = clamped_target();
					end
				end else begin
					event_count = next_event[WIN_W-1:0];
				end
				// The sample that closes a window counts towards the next one.
				sample_count = sample_count + CNT_W'(1);
				sample_sum = sample_sum + SUM_W'(value);
			end else begin
				next_tick = {1'b0, tick_count} + (RAMP_W+1)'(1);
				if (next_tick > {1'b0, ramp_interval}) begin
					tick_count = '0;
					target = clamped_target();
					if (period > target) begin
						period = period - alddm_pkg::PERIOD_STEP;
					end else if (period < target) begin
						period = period + alddm_pkg::PERIOD_STEP;
					end
				end else begin
					tick_count = next_tick[RAMP_W-1:0];
				end
			end
			expected.avg_light = light;
			expected.new_average = fresh;
			expected.hundreds = hundreds;
			expected.tens = tens;
			expected.ones = ones;
			expected.scan_period = period;
			pending_results.push_back(expected);
		endfunction

		function void report(string what, dimmer_result_t want, dimmer_result_t got);
			mismatch_count++;
			if (mismatch_count <= 10) begin
				$display("%s: expected light %0d fresh %0b digits %0d %0d %0d period %0d,",
					what, want.avg_light, want.new_average, want.hundreds, want.tens,
					want.ones, want.scan_period,
					" got light %0d fresh %0b digits %0d %0d %0d period %0d",
					got.avg_light, got.new_average,
					got.hundreds, got.tens, got.ones, got.scan_period);
			end
		endfunction

		// Compare an accepted result with the oldest one waiting.
		function void check_result(dimmer_result_t got);
			dimmer_result_t want;
			if (pending_results.size() == 0) begin
				want = '0;
				report("Result with no request waiting", want, got);
			end else begin
				want = pending_results.pop_front();
				if (got.avg_light !== want.avg_light || got.new_average !== want.new_average
						|| got.hundreds !== want.hundreds || got.tens !== want.tens
						|| got.ones !== want.ones || got.scan_period !== want.scan_period) begin
					report("Result mismatch", want, got);
				end
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	bit                    idle_on;
	int                    stall_left = 0;
	int                    cycle_count = 0;
	dimmer_result_t        seen_result;
	dimmer_tracker         tracker;

	alddm_item_if   item_ch ();
	alddm_result_if result_ch ();

	ambient_light_display_dimmer #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Watchdog on the length of the run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Receiver side: ready drops in random bursts while idling is enabled.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			result_ch.ready = 1'b0;
			stall_left--;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			result_ch.ready = 1'b0;
			stall_left = $urandom_range(1, 9) - 1;
		end else begin
			result_ch.ready = 1'b1;
		end
	end

	// Both handshakes are observed at the rising edge; requests are noted before results.
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready) begin
				tracker.note_request(item_ch.command, item_ch.sample);
			end
			if (result_ch.valid && result_ch.ready) begin
				seen_result.avg_light = result_ch.avg_light;
				seen_result.new_average = result_ch.new_average;
				seen_result.hundreds = result_ch.digit_hundreds;
				seen_result.tens = result_ch.digit_tens;
				seen_result.ones = result_ch.digit_ones;
				seen_result.scan_period = result_ch.scan_period;
				tracker.check_result(seen_result);
			end
		end
	end

	// Present one request, after a random gap when idling is on, and wait until it is taken.
	task automatic send_request(input logic cmd, input logic [SAMPLE_W-1:0] value);
		int gap;
		gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
		@(negedge clk);
		if (gap > 0) begin
			item_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid = 1'b1;
		item_ch.command = cmd;
		item_ch.sample = value;
		do @(posedge clk); while (!item_ch.ready);
	endtask

	task automatic stop_requests();
		@(negedge clk);
		item_ch.valid = 1'b0;
	endtask

	// Wait until every expected result has come back and the block has settled.
	task automatic drain();
		while (tracker.outstanding() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input alddm_pkg::cfg_reg_t idx,
			input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		tracker.write_register(idx, value);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Light samples leaning towards the range where the scan period changes.
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0, 1, 2, 3: return SAMPLE_W'($urandom_range(0, 300));
			4, 5: return SAMPLE_W'($urandom());
			6: return ($urandom_range(0, 1) == 0) ? '0 : '1;
			default: return SAMPLE_W'($urandom_range(225, 260));
		endcase
	endfunction

	initial begin
		tracker = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = alddm_pkg::REG_WINDOW_LEN;
		cfg_data = '0;
		item_ch.valid = 1'b0;
		item_ch.command = alddm_pkg::CMD_SAMPLE;
		item_ch.sample = '0;
		idle_on = 1'b1;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Ticks under the reset settings: no ramp yet.
		repeat (3) send_request(alddm_pkg::CMD_TICK, 16'h5A5A);
		stop_requests();
		drain();

		// Zero window and a ramp on every tick; ramps run before any average.
		write_register(alddm_pkg::REG_WINDOW_LEN, '0);
		write_register(alddm_pkg::REG_RAMP_INTERVAL, '0);
		send_request(alddm_pkg::CMD_TICK, 16'hFFFF);
		send_request(alddm_pkg::CMD_TICK, 16'h0000);
		// An average over no samples, then averages of zero.
		send_request(alddm_pkg::CMD_SAMPLE, 16'h0000);
		send_request(alddm_pkg::CMD_SAMPLE, 16'h0000);
		send_request(alddm_pkg::CMD_SAMPLE, 16'hFFFF);
		// The first nonzero average clamps the light and sets the period at once.
		send_request(alddm_pkg::CMD_SAMPLE, 16'h0001);
		send_request(alddm_pkg::CMD_TICK, 16'h0000);
		send_request(alddm_pkg::CMD_SAMPLE, 16'd45);
		send_request(alddm_pkg::CMD_TICK, 16'h0000);
		send_request(alddm_pkg::CMD_SAMPLE, 16'd240);
		send_request(alddm_pkg::CMD_TICK, 16'h0000);
		send_request(alddm_pkg::CMD_SAMPLE, 16'h0000);
		send_request(alddm_pkg::CMD_TICK, 16'h0000);
		send_request(alddm_pkg::CMD_TICK, 16'h0000);
		stop_requests();
		drain();

		// Window shrunk part way through: the next sample closes it at once.
		write_register(alddm_pkg::REG_WINDOW_LEN, 12'd10);
		repeat (5) send_request(alddm_pkg::CMD_SAMPLE, pick_sample());
		stop_requests();
		drain();
		write_register(alddm_pkg::REG_WINDOW_LEN, 12'd2);
		send_request(alddm_pkg::CMD_SAMPLE, pick_sample());
		stop_requests();
		drain();

		// Both counters at full width: the ramp still fires on the 256th tick.
		write_register(alddm_pkg::REG_WINDOW_LEN, 12'd4095);
		write_register(alddm_pkg::REG_RAMP_INTERVAL, 12'd255);
		idle_on = 1'b0;
		for (int n = 0; n < WIDE_TICKS; n++) begin
			send_request(alddm_pkg::CMD_TICK, SAMPLE_W'($urandom()));
			if (n % 10 == 9) begin
				send_request(alddm_pkg::CMD_SAMPLE, 16'hFFFF);
			end
		end
		stop_requests();
		drain();

		// Random mixes of samples and ticks under a range of settings.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			idle_on = (ph != RANDOM_PHASES - 1);
			case (ph)
				0: write_register(alddm_pkg::REG_WINDOW_LEN, 12'd1);
				3: write_register(alddm_pkg::REG_WINDOW_LEN,
					CFG_DATA_W'($urandom_range(20, 40)));
				default: write_register(alddm_pkg::REG_WINDOW_LEN,
					CFG_DATA_W'($urandom_range(1, 10)));
			endcase
			case (ph)
				1: write_register(alddm_pkg::REG_RAMP_INTERVAL, '0);
				4: write_register(alddm_pkg::REG_RAMP_INTERVAL, 12'd255);
				default: write_register(alddm_pkg::REG_RAMP_INTERVAL,
					CFG_DATA_W'($urandom_range(0, 5)));
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 9) < 6) begin
					send_request(alddm_pkg::CMD_SAMPLE, pick_sample());
				end else begin
					send_request(alddm_pkg::CMD_TICK, SAMPLE_W'($urandom()));
				end
			end
			stop_requests();
			drain();
		end

		repeat (60) @(posedge clk);
		if (tracker.mismatch_count == 0 && tracker.outstanding() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ===== ambient_light_display_dimmer.f =====
design/alddm_pkg.sv
design/alddm_item_if.sv
design/alddm_result_if.sv
design/alddm_calc.sv
design/ambient_light_display_dimmer.sv
tb/ambient_light_display_dimmer_test.sv
